[hw/rtl/text_window_console_macros.svh]
// Assertion macros shared by the text window console RTL.
// No dependencies; included by the files that carry assertions.
`ifndef TEXT_WINDOW_CONSOLE_MACROS_SVH
`define TEXT_WINDOW_CONSOLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TWC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/twc_pkg.sv]
// Types and constants of the text window console.
// No dependencies; used by text_window_console and the testbench.
package twc_pkg;

  localparam int CELL_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // Operation codes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Control characters
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_BLANK     = 8'h20;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOR = 3'd5;

  // Register reset values
  localparam logic [6:0] RST_WIN_LEFT   = 7'd0;
  localparam logic [4:0] RST_WIN_TOP    = 5'd0;
  localparam logic [6:0] RST_WIN_WIDTH  = 7'd80;
  localparam logic [4:0] RST_WIN_HEIGHT = 5'd25;
  localparam logic [3:0] RST_TEXT_COLOR = 4'd7;
  localparam logic [3:0] RST_BACK_COLOR = 4'd0;

  typedef struct packed {
    logic        operation;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_data;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
  } out_item_t;

endpackage

[hw/rtl/twc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module twc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/twc_addr.sv]
// Shared cell address unit: screen column and row to linear address, with clipping.
// No dependencies; instanced by the top level.
module twc_addr #(
  parameter int COLS = 80,
  parameter int ROWS = 25,
  localparam int AW  = $clog2(COLS * ROWS)
) (
  input  logic [7:0]    col,
  input  logic [6:0]    row,
  output logic [AW-1:0] addr,
  output logic          on_screen
);

  localparam int PW = 16;

  logic [PW-1:0] lin;

  // row * COLS + col; the product stays below 2^15 for every legal screen size
  assign lin       = PW'(row) * PW'(COLS) + PW'(col);
  assign addr      = lin[AW-1:0];
  assign on_screen = (int'(col) < COLS) && (int'(row) < ROWS);

endmodule

[hw/rtl/text_window_console.sv]
// Top level of the text window console: sequencer, window registers, screen store.
// Depends on twc_pkg, twc_addr, twc_ram and text_window_console_macros.svh.
//
// Usage
//   in channel  : in_valid / in_stall / in_data. An item is either a put of one
//                 character into the window or a read of one screen cell.
//   out channel : out_valid / out_stall / out_data. Exactly one item per input item,
//                 carrying the cell read (zero on a put) and the cursor after it.
//   cfg port    : cfg_we / cfg_index / cfg_wdata, written while the block is idle.
// Timing
//   Puts and scrolls use one shared address unit; all items use one RAM port pair.
//   A read steps through S_READ, S_RDATA and S_DONE, a put through S_PUT and S_DONE;
//   out_valid rises when S_DONE loads the result. A scroll adds an S_SCR_RD and an
//   S_SCR_WR step per interior cell moved ((rows-1) * cols; only S_SCR_RD if its
//   source is off-screen) plus an S_BLANK step per cell of the blanked bottom row.
//   in_stall is high while an item is in progress; the next item is taken as
//   soon as the sequencer is back in idle, even if a result still waits.
// Reset
//   After rst_n the screen store is swept to zero, one cell per cycle, over all
//   SCREEN_COLS * SCREEN_ROWS cells (2000 by default). in_stall stays high
//   meanwhile; configuration writes are taken throughout.
// Stall
//   A finished result waits in the output register; while out_stall holds it,
//   the sequencer parks in its final step and accepts nothing further.
`include "text_window_console_macros.svh"

module text_window_console #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  twc_pkg::in_item_t                   in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output twc_pkg::out_item_t                  out_data,
  // configuration port
  input  logic                                cfg_we,
  input  logic [twc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [twc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW    = $clog2(CELLS);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_RDATA,
    S_PUT,
    S_SCR_RD,
    S_SCR_WR,
    S_BLANK,
    S_DONE
  } state_t;

  state_t state_r;

  // window registers
  logic [6:0] win_left_r, win_width_r;
  logic [4:0] win_top_r, win_height_r;
  logic [3:0] text_color_r, back_color_r;

  // item and cursor
  twc_pkg::in_item_t  item_r;
  twc_pkg::out_item_t out_data_r;
  logic               out_valid_r;
  logic [6:0]         cur_col_r;
  logic [4:0]         cur_row_r;
  logic [twc_pkg::CELL_W-1:0] cell_r;

  // sweep counters
  logic [6:0]    xx_r;
  logic [4:0]    yy_r;
  logic [AW-1:0] clr_cnt_r;

  // window geometry
  logic [7:0] ox;
  logic [6:0] oy;
  logic [6:0] maxw;
  logic [4:0] maxh;
  logic       has_interior;
  logic [7:0] attr;

  assign ox           = {1'b0, win_left_r} + 8'd1;
  assign oy           = {2'b00, win_top_r} + 7'd1;
  assign maxw         = win_width_r - 7'd2;
  assign maxh         = win_height_r - 5'd2;
  assign has_interior = (win_width_r >= 7'd3) && (win_height_r >= 5'd3);
  assign attr         = {back_color_r, text_color_r};

  // character handling of a put
  logic [7:0] cx_ext, cx_inc, cx_new, put_cx;
  logic [5:0] cy_ext, cy_new;
  logic       put_we;
  logic [7:0] put_ch;
  logic       need_scroll;

  always_comb begin
    cx_ext = {1'b0, cur_col_r};
    cy_ext = {1'b0, cur_row_r};
    cx_inc = cx_ext + 8'd1;
    cx_new = cx_ext;
    cy_new = cy_ext;
    put_cx = cx_ext;
    put_we = 1'b0;
    put_ch = item_r.char_code;
    case (item_r.char_code)
      twc_pkg::CH_NEWLINE: begin
        cx_new = '0;
        cy_new = cy_ext + 6'd1;
      end
      twc_pkg::CH_RETURN: begin
        cx_new = '0;
      end
      twc_pkg::CH_BACKSPACE: begin
        // step back and blank, only away from the left edge
        if (cur_col_r != '0) begin
          cx_new = cx_ext - 8'd1;
          put_cx = cx_ext - 8'd1;
          put_we = 1'b1;
          put_ch = twc_pkg::CH_BLANK;
        end
      end
      default: begin
        put_we = 1'b1;
        if (cx_inc >= {1'b0, maxw}) begin
          cx_new = '0;
          cy_new = cy_ext + 6'd1;
        end else begin
          cx_new = cx_inc;
        end
      end
    endcase
    need_scroll = cy_new >= {1'b0, maxh};
  end

  // shared address unit
  logic [7:0]    au_col;
  logic [6:0]    au_row;
  logic [AW-1:0] au_addr;
  logic          au_on;

  always_comb begin
    au_col = ox + {1'b0, xx_r};
    au_row = oy + {2'b00, yy_r};
    case (state_r)
      S_PUT: begin
        au_col = ox + put_cx;
        au_row = oy + {2'b00, cur_row_r};
      end
      S_SCR_RD: begin
        // source row sits one below the destination
        au_row = oy + {2'b00, yy_r} + 7'd1;
      end
      S_BLANK: begin
        au_row = oy + {2'b00, maxh} - 7'd1;
      end
      default: begin
        au_row = oy + {2'b00, yy_r};
      end
    endcase
  end

  twc_addr #(
    .COLS (SCREEN_COLS),
    .ROWS (SCREEN_ROWS)
  ) u_addr (
    .col       (au_col),
    .row       (au_row),
    .addr      (au_addr),
    .on_screen (au_on)
  );

  // screen store
  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [twc_pkg::CELL_W-1:0] ram_wdata, ram_rdata;
  logic                       rd_in_range;

  assign rd_in_range = int'(item_r.cell_index) < CELLS;

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = au_addr;
    ram_raddr = au_addr;
    ram_wdata = {attr, twc_pkg::CH_BLANK};
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      S_READ: begin
        ram_re    = rd_in_range;
        ram_raddr = AW'(item_r.cell_index);
      end
      S_PUT: begin
        ram_we    = has_interior && put_we && au_on;
        ram_wdata = {attr, put_ch};
      end
      S_SCR_RD: begin
        ram_re = au_on;
      end
      S_SCR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      S_BLANK: begin
        ram_we = au_on;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  twc_ram #(
    .WIDTH (twc_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // end-of-sweep conditions
  logic last_x, last_y;
  assign last_x = xx_r == (maxw - 7'd1);
  assign last_y = yy_r == (maxh - 5'd2);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= twc_pkg::RST_WIN_LEFT;
      win_top_r    <= twc_pkg::RST_WIN_TOP;
      win_width_r  <= twc_pkg::RST_WIN_WIDTH;
      win_height_r <= twc_pkg::RST_WIN_HEIGHT;
      text_color_r <= twc_pkg::RST_TEXT_COLOR;
      back_color_r <= twc_pkg::RST_BACK_COLOR;
    end else if (cfg_we) begin
      case (cfg_index)
        twc_pkg::CFG_WIN_LEFT:   win_left_r   <= cfg_wdata;
        twc_pkg::CFG_WIN_TOP:    win_top_r    <= cfg_wdata[4:0];
        twc_pkg::CFG_WIN_WIDTH:  win_width_r  <= cfg_wdata;
        twc_pkg::CFG_WIN_HEIGHT: win_height_r <= cfg_wdata[4:0];
        twc_pkg::CFG_TEXT_COLOR: text_color_r <= cfg_wdata[3:0];
        twc_pkg::CFG_BACK_COLOR: back_color_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      out_valid_r <= 1'b0;
      xx_r        <= '0;
      yy_r        <= '0;
    end else begin
      // drop the result once taken; the final step loads the next one itself
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (int'(clr_cnt_r) == CELLS - 1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            cell_r  <= '0;
            state_r <= (in_data.operation == twc_pkg::OP_READ) ? S_READ : S_PUT;
          end
        end
        S_READ: begin
          state_r <= S_RDATA;
        end
        S_RDATA: begin
          cell_r  <= rd_in_range ? ram_rdata : '0;
          state_r <= S_DONE;
        end
        S_PUT: begin
          if (!has_interior) begin
            state_r <= S_DONE;
          end else begin
            cur_col_r <= cx_new[6:0];
            xx_r      <= '0;
            yy_r      <= '0;
            if (need_scroll) begin
              cur_row_r <= maxh - 5'd1;
              state_r   <= (maxh > 5'd1) ? S_SCR_RD : S_BLANK;
            end else begin
              cur_row_r <= cy_new[4:0];
              state_r   <= S_DONE;
            end
          end
        end
        S_SCR_RD, S_SCR_WR: begin
          // skip the move when the source is off-screen
          if (state_r == S_SCR_RD && au_on) begin
            state_r <= S_SCR_WR;
          end else if (last_x) begin
            xx_r    <= '0;
            yy_r    <= yy_r + 5'd1;
            state_r <= last_y ? S_BLANK : S_SCR_RD;
          end else begin
            xx_r    <= xx_r + 7'd1;
            state_r <= S_SCR_RD;
          end
        end
        S_BLANK: begin
          if (last_x) begin
            state_r <= S_DONE;
          end else begin
            xx_r <= xx_r + 7'd1;
          end
        end
        S_DONE: begin
          // hold while the previous result is still stalled
          if (!out_valid_r || !out_stall) begin
            out_data_r.cell_data  <= cell_r;
            out_data_r.cursor_col <= cur_col_r;
            out_data_r.cursor_row <= cur_row_r;
            out_valid_r           <= 1'b1;
            state_r               <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TWC_ASSERT_NOW(a_idle_no_write, clk, rst_n, state_r == S_IDLE, !ram_we,
    "screen store written while idle")
  `TWC_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && !in_stall,
    state_r == S_READ || state_r == S_PUT, "accepted item did not start")
  `TWC_ASSERT_NOW(a_scroll_row_above, clk, rst_n, state_r == S_SCR_WR,
    32'(ram_waddr) + 32'(SCREEN_COLS) == 32'($past(ram_raddr)),
    "scroll move not one row up")

endmodule

[sim/testbench.sv]
// Self-checking testbench of text_window_console: puts and cell reads, window set-ups.
// Depends on twc_pkg and the RTL of text_window_console; the expected results
// come from a shadow screen kept inside this file.
`timescale 1ns / 1ps

module testbench;

  localparam int COLS  = 80;
  localparam int ROWS  = 25;
  localparam int CELLS = COLS * ROWS;

  // Shadow of the console: screen store, cursor and window registers, plus the
  // queue of results still owed by the block.
  class console_shadow;
    logic [15:0]         shadow_cells [CELLS];
    logic [6:0]          cur_col;
    logic [4:0]          cur_row;
    int                  win_left, win_top, win_width, win_height;
    logic [3:0]          fg_color, bg_color;
    twc_pkg::out_item_t  awaited[$];
    int                  mismatch_count;

    function new();
      foreach (shadow_cells[i]) shadow_cells[i] = '0;
      cur_col        = '0;
      cur_row        = '0;
      win_left       = twc_pkg::RST_WIN_LEFT;
      win_top        = twc_pkg::RST_WIN_TOP;
      win_width      = twc_pkg::RST_WIN_WIDTH;
      win_height     = twc_pkg::RST_WIN_HEIGHT;
      fg_color       = twc_pkg::RST_TEXT_COLOR;
      bg_color       = twc_pkg::RST_BACK_COLOR;
      mismatch_count = 0;
    endfunction

    function void set_reg(logic [twc_pkg::CFG_IDX_W-1:0] idx,
                          logic [twc_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        twc_pkg::CFG_WIN_LEFT:   win_left   = val;
        twc_pkg::CFG_WIN_TOP:    win_top    = val[4:0];
        twc_pkg::CFG_WIN_WIDTH:  win_width  = val;
        twc_pkg::CFG_WIN_HEIGHT: win_height = val[4:0];
        twc_pkg::CFG_TEXT_COLOR: fg_color   = val[3:0];
        twc_pkg::CFG_BACK_COLOR: bg_color   = val[3:0];
        default: ;
      endcase
    endfunction

    function bit has_interior();
      return (win_width > 2) && (win_height > 2);
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Cells off the screen are dropped.
    function void put_cell(int col, int row, logic [7:0] ch);
      if (col < 0 || col >= COLS || row < 0 || row >= ROWS) return;
      shadow_cells[row * COLS + col] = {bg_color, fg_color, ch};
    endfunction

    function void apply_put(logic [7:0] ch);
      int iw, ih, cx, cy, ox, oy, dr, c;
      iw = win_width - 2;
      ih = win_height - 2;
      cx = cur_col;
      cy = cur_row;
      ox = win_left + 1;
      oy = win_top + 1;
      if (iw <= 0 || ih <= 0) return;
      if (ch == twc_pkg::CH_NEWLINE) begin
        cx = 0;
        cy++;
      end else if (ch == twc_pkg::CH_RETURN) begin
        cx = 0;
      end else if (ch == twc_pkg::CH_BACKSPACE) begin
        if (cx > 0) begin
          cx--;
          put_cell(ox + cx, oy + cy, twc_pkg::CH_BLANK);
        end
      end else begin
        put_cell(ox + cx, oy + cy, ch);
        cx++;
        if (cx >= iw) begin
          cx = 0;
          cy++;
        end
      end
      if (cy >= ih) begin
        // scroll the interior up; moves touching off-screen cells are skipped
        for (int yy = 0; yy < ih - 1; yy++) begin
          dr = oy + yy;
          if (dr + 1 >= ROWS) continue;
          for (int xx = 0; xx < iw; xx++) begin
            c = ox + xx;
            if (c >= COLS) continue;
            shadow_cells[dr * COLS + c] = shadow_cells[(dr + 1) * COLS + c];
          end
        end
        for (int xx = 0; xx < iw; xx++) put_cell(ox + xx, oy + ih - 1, twc_pkg::CH_BLANK);
        cy = ih - 1;
      end
      cur_col = cx[6:0];
      cur_row = cy[4:0];
    endfunction

    function void note_item(twc_pkg::in_item_t it);
      twc_pkg::out_item_t e;
      e.cell_data = '0;
      if (it.operation == twc_pkg::OP_READ) begin
        if (it.cell_index < CELLS) e.cell_data = shadow_cells[it.cell_index];
      end else begin
        apply_put(it.char_code);
      end
      e.cursor_col = cur_col;
      e.cursor_row = cur_row;
      awaited.push_back(e);
    endfunction

    task report_mismatch(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatch_count++;
    endtask

    task check_result(twc_pkg::out_item_t got);
      twc_pkg::out_item_t e;
      if (awaited.size() == 0) begin
        report_mismatch("result with nothing awaited");
        return;
      end
      e = awaited.pop_front();
      if (got.cell_data !== e.cell_data)
        report_mismatch($sformatf("cell_data %h, expected %h", got.cell_data, e.cell_data));
      if (got.cursor_col !== e.cursor_col)
        report_mismatch($sformatf("cursor_col %0d, expected %0d", got.cursor_col, e.cursor_col));
      if (got.cursor_row !== e.cursor_row)
        report_mismatch($sformatf("cursor_row %0d, expected %0d", got.cursor_row, e.cursor_row));
    endtask
  endclass

  // Every input holds a known value from time zero; reset is low from the start.
  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  twc_pkg::in_item_t              in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  twc_pkg::out_item_t             out_data;
  logic                           cfg_we    = 1'b0;
  logic [twc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [twc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  console_shadow sb;
  int            counted_items;

  text_window_console #(
    .SCREEN_COLS(COLS),
    .SCREEN_ROWS(ROWS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Check every result item taken at this edge; values seen here are the
  // ones from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver back-pressure: mostly short stalls, a few long ones, and
  // stretches with no stall at all. One assignment per pass, then time moves.
  initial begin
    int r;
    int len;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        out_stall <= 1'b0;
        len = $urandom_range(1, 4);
      end else if (r < 55) begin
        out_stall <= 1'b1;
        len = $urandom_range(1, 3);
      end else if (r < 62) begin
        out_stall <= 1'b1;
        len = $urandom_range(10, 40);
      end else if (r < 70) begin
        out_stall <= 1'b0;
        len = $urandom_range(40, 150);
      end else begin
        out_stall <= 1'b0;
        len = $urandom_range(1, 8);
      end
      repeat (len) @(posedge clk);
    end
  end

  // Hard stop well beyond the slowest legal run, including the clearing sweep.
  initial begin
    #200_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic twc_pkg::in_item_t put_item(logic [7:0] ch);
    twc_pkg::in_item_t it;
    it.operation  = twc_pkg::OP_PUT;
    it.char_code  = ch;
    it.cell_index = 11'($urandom_range(0, 2047));
    return it;
  endfunction

  function automatic twc_pkg::in_item_t read_item(int idx);
    twc_pkg::in_item_t it;
    it.operation  = twc_pkg::OP_READ;
    it.char_code  = 8'($urandom_range(0, 255));
    it.cell_index = 11'(idx);
    return it;
  endfunction

  // Sender gap: mostly none or short, now and then long.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item, hold it until taken, then note it and idle for the gap.
  // Valid stays high when gap is zero so back-to-back items need no toggle.
  task automatic send(twc_pkg::in_item_t it, int gap);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it);
    if (it.operation == twc_pkg::OP_READ || sb.has_interior()) counted_items++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, wait until every owed result is in, then let the sequencer settle.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [twc_pkg::CFG_IDX_W-1:0] idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= twc_pkg::CFG_DATA_W'(val);
    @(posedge clk);
    sb.set_reg(idx, twc_pkg::CFG_DATA_W'(val));
  endtask

  task automatic configure(int l, int t, int w, int h, int fg, int bg);
    write_reg(twc_pkg::CFG_WIN_LEFT, l);
    write_reg(twc_pkg::CFG_WIN_TOP, t);
    write_reg(twc_pkg::CFG_WIN_WIDTH, w);
    write_reg(twc_pkg::CFG_WIN_HEIGHT, h);
    write_reg(twc_pkg::CFG_TEXT_COLOR, fg);
    write_reg(twc_pkg::CFG_BACK_COLOR, bg);
    cfg_we <= 1'b0;
  endtask

  // Directed set: field extremes, each control byte, no-interior windows,
  // clipping at the screen edges, scroll, and a cursor left outside a
  // shrunken window.
  task automatic directed_items();
    // reset window: whole screen, grey on black
    send(read_item(0), idle_gap());
    send(read_item(CELLS - 1), idle_gap());
    send(read_item(CELLS), idle_gap());          // just past the screen
    send(read_item(2047), idle_gap());           // top of the index field
    send(put_item(8'h41), idle_gap());
    send(put_item(8'hFF), idle_gap());
    send(put_item(8'h00), idle_gap());
    send(put_item(twc_pkg::CH_BACKSPACE), idle_gap());    // step back and blank
    send(put_item(twc_pkg::CH_RETURN), idle_gap());
    send(put_item(twc_pkg::CH_BACKSPACE), idle_gap());    // column zero: nothing happens
    send(put_item(twc_pkg::CH_NEWLINE), idle_gap());
    send(read_item(COLS + 1), idle_gap());
    send(read_item(COLS + 3), idle_gap());

    // window with no interior ignores puts
    quiesce();
    configure(79, 24, 0, 0, 15, 15);
    send(put_item(8'h78), idle_gap());
    quiesce();
    configure(79, 24, 80, 2, 15, 15);
    send(put_item(twc_pkg::CH_NEWLINE), idle_gap());

    // narrow window hanging off the right edge; the second newline scrolls it
    quiesce();
    configure(75, 22, 9, 4, 15, 15);
    send(put_item(8'h51), idle_gap());
    repeat (4) send(put_item(8'h61), idle_gap());   // last one lands off-screen
    send(put_item(twc_pkg::CH_NEWLINE), idle_gap());
    send(put_item(twc_pkg::CH_NEWLINE), idle_gap());
    send(read_item(23 * COLS + 76), idle_gap());

    // one-line window with the cursor left below it
    quiesce();
    configure(0, 0, 5, 3, 0, 0);
    send(put_item(8'h6B), idle_gap());
    send(read_item(2 * COLS + 1), idle_gap());
  endtask

  // One random window set-up followed by a burst of items. Most windows are
  // small so that scrolls stay cheap; a few cover the whole screen or run off it.
  task automatic random_phase();
    int kind, l, t, w, h, n, r, idx;
    bit calm;
    twc_pkg::in_item_t it;
    kind = $urandom_range(0, 11);
    l = $urandom_range(0, 79);
    t = $urandom_range(0, 24);
    w = $urandom_range(3, 24);
    h = $urandom_range(3, 10);
    n = $urandom_range(20, 40);
    case (kind)
      0: begin
        if ($urandom_range(0, 1)) w = $urandom_range(0, 2);
        else h = $urandom_range(0, 2);
        n = 8;
      end
      1: begin
        l = 0;
        t = 0;
        w = 80;
        h = 25;
      end
      2: begin
        l = $urandom_range(60, 79);
        t = $urandom_range(15, 24);
        w = $urandom_range(3, 80);
        h = $urandom_range(3, 25);
      end
      default: ;
    endcase
    quiesce();
    configure(l, t, w, h, $urandom_range(0, 15), $urandom_range(0, 15));
    calm = ($urandom_range(0, 3) == 0);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        // mostly read back the window area, sometimes anywhere in the field
        if (r < 20) idx = (t + $urandom_range(0, h)) * COLS + l + $urandom_range(0, w);
        else idx = $urandom_range(0, 2047);
        it = read_item(idx);
      end else if (r < 37) begin
        it = put_item(twc_pkg::CH_NEWLINE);
      end else if (r < 42) begin
        it = put_item(twc_pkg::CH_RETURN);
      end else if (r < 50) begin
        it = put_item(twc_pkg::CH_BACKSPACE);
      end else begin
        it = put_item(8'($urandom_range(0, 255)));
      end
      send(it, calm ? 0 : idle_gap());
    end
  endtask

  initial begin
    sb = new();
    counted_items = 0;
    // hold reset, then release it on an edge
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    directed_items();
    counted_items = 0;
    while (counted_items < 450) random_phase();

    // drain and let any stray result show itself
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[text_window_console.f]
+incdir+hw/rtl
hw/rtl/twc_pkg.sv
hw/rtl/twc_ram.sv
hw/rtl/twc_addr.sv
hw/rtl/text_window_console.sv
sim/testbench.sv
